// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the dirty rectangle table modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define DRM_ASSERT(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error(msg);

// cause at one edge implies effect at the next edge
`define DRM_ASSERT_NEXT(label, clk_sig, rst_sig, cause, effect, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) \
    (cause) |=> (effect)) else $error(msg);

`endif

// ===== sv/drm_pkg.sv =====
// ---------------------------------------------------------------------------
// drm_pkg
// types and codes for the dirty rectangle merge table
// ---------------------------------------------------------------------------
package drm_pkg;

  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_FLUSH = 1'b1
  } act_t;

  typedef enum logic [2:0] {
    KIND_MERGED   = 3'd0,
    KIND_INSERTED = 3'd1,
    KIND_DROPPED  = 3'd2,
    KIND_FLUSHED  = 3'd3,
    KIND_EMPTY    = 3'd4
  } kind_t;

  typedef struct packed {
    act_t               action;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [15:0]        rect_w;
    logic [15:0]        rect_h;
  } item_word_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [16:0]        out_w;
    logic [16:0]        out_h;
    logic               last;
  } result_word_t;

  // one stored rectangle
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [16:0]        width;
    logic [16:0]        height;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic  ld_in;
    logic  wr_en;
    logic  wr_union;
    logic  res_ld;
    kind_t res_kind;
    logic  out_ld_res;
    logic  out_ld_flush;
    logic  flush_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/drm_stream_if.sv =====
// ---------------------------------------------------------------------------
// drm_stream_if
// valid/ready channel carrying one word per handshake
// ---------------------------------------------------------------------------
interface drm_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/drm_ctrl.sv =====
// ---------------------------------------------------------------------------
// drm_ctrl
// sequencer for search, insert and flush over the rectangle table
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module drm_ctrl import drm_pkg::*; #(
  parameter int  TABLE_DEPTH = 16,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  input  act_t          item_action,
  output logic          item_ready,
  input  dp_stat_t      stat,
  output dp_cmd_t       cmd,
  output logic [IW-1:0] rd_addr,
  output logic [IW-1:0] wr_addr
);

  state_t        state, state_next;
  logic [IW-1:0] idx, idx_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [IW-1:0] newest;
  logic [IW-1:0] idx_dn;

  assign newest = (cnt == '0) ? '0 : IW'(cnt - 1'b1);
  assign idx_dn = (idx == '0) ? '0 : IW'(idx - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.res_kind = KIND_MERGED;
    rd_addr    = idx;
    wr_addr    = idx;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        rd_addr    = newest;
        if (item_valid) begin
          cmd.ld_in = 1'b1;
          idx_next  = newest;
          if (item_action == ACT_FLUSH) begin
            if (cnt == '0) begin
              cmd.res_ld   = 1'b1;
              cmd.res_kind = KIND_EMPTY;
              state_next   = ST_EMIT;
            end else begin
              state_next = ST_FLUSH;
            end
          end else begin
            state_next = (cnt == '0) ? ST_INSERT : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // entry idx is on the read port, next one is being fetched
        rd_addr = idx_dn;
        if (stat.hit) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_union = 1'b1;
          cmd.res_ld   = 1'b1;
          cmd.res_kind = KIND_MERGED;
          state_next   = ST_EMIT;
        end else if (idx == '0) begin
          state_next = ST_INSERT;
        end else begin
          idx_next = idx_dn;
        end
      end
      ST_INSERT: begin
        cmd.res_ld = 1'b1;
        if (cnt == CW'(TABLE_DEPTH)) begin
          cmd.res_kind = KIND_DROPPED;
        end else begin
          cmd.res_kind = KIND_INSERTED;
          cmd.wr_en    = 1'b1;
          wr_addr      = IW'(cnt);
          cnt_next     = CW'(cnt + 1'b1);
        end
        state_next = ST_EMIT;
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.out_ld_flush = 1'b1;
          cmd.flush_last   = (idx == '0);
          if (idx == '0) begin
            cnt_next   = '0;
            state_next = ST_IDLE;
          end else begin
            idx_next = idx_dn;
            rd_addr  = idx_dn;
          end
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_ld_res = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `DRM_ASSERT(a_cnt_bound, clk, rst, cnt <= CW'(TABLE_DEPTH), "entry count beyond table depth")
  `DRM_ASSERT(a_no_wr_flush, clk, rst, !(state == ST_FLUSH && cmd.wr_en), "table write during flush")
  `DRM_ASSERT_NEXT(a_flush_start, clk, rst, item_valid && item_ready && item_action == ACT_FLUSH && cnt != '0, state == ST_FLUSH, "flush of filled table did not start")
  `DRM_ASSERT_NEXT(a_flush_clear, clk, rst, cmd.out_ld_flush && cmd.flush_last, cnt == '0, "table not empty after flush")

endmodule

// ===== sv/drm_datapath.sv =====
// ---------------------------------------------------------------------------
// drm_datapath
// rectangle storage, overlap and union logic, result registers
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module drm_datapath import drm_pkg::*; #(
  parameter int  TABLE_DEPTH = 16,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  item_word_t    in_data,
  input  dp_cmd_t       cmd,
  input  logic [IW-1:0] rd_addr,
  input  logic [IW-1:0] wr_addr,
  output dp_stat_t      stat,
  output logic          out_valid,
  input  logic          out_ready,
  output result_word_t  out_data
);

  typedef struct packed {
    logic signed [15:0] lo;
    logic [16:0]        len;
  } span_t;

  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_q;
  logic signed [15:0] in_x, in_y;
  logic [16:0]        in_w, in_h;
  entry_t             in_e, uni_e, wr_e;
  span_t              ux, uy;
  result_word_t       res;
  logic               out_v;
  result_word_t       out_q;

  // positive-length overlap of [a, a+al) and [b, b+bl)
  function automatic logic span_hit(logic signed [15:0] a, logic [16:0] al,
                                    logic signed [15:0] b, logic [16:0] bl);
    logic signed [17:0] a0, b0, ha, hb, lo, hi;
    a0 = {{2{a[15]}}, a};
    b0 = {{2{b[15]}}, b};
    ha = a0 + $signed({1'b0, al});
    hb = b0 + $signed({1'b0, bl});
    lo = (a0 > b0) ? a0 : b0;
    hi = (ha < hb) ? ha : hb;
    return hi > lo;
  endfunction

  function automatic span_t span_join(logic signed [15:0] a, logic [16:0] al,
                                      logic signed [15:0] b, logic [16:0] bl);
    logic signed [17:0] a0, b0, ha, hb, lo, hi, len;
    span_t              s;
    a0 = {{2{a[15]}}, a};
    b0 = {{2{b[15]}}, b};
    ha = a0 + $signed({1'b0, al});
    hb = b0 + $signed({1'b0, bl});
    lo = (a0 < b0) ? a0 : b0;
    hi = (ha > hb) ? ha : hb;
    len   = hi - lo;
    s.lo  = lo[15:0];
    s.len = len[16:0];
    return s;
  endfunction

  assign in_e = '{left: in_x, top: in_y, width: in_w, height: in_h};

  assign ux = span_join(rd_q.left, rd_q.width, in_x, in_w);
  assign uy = span_join(rd_q.top, rd_q.height, in_y, in_h);
  assign uni_e = '{left: ux.lo, top: uy.lo, width: ux.len, height: uy.len};

  assign stat.hit = span_hit(rd_q.left, rd_q.width, in_x, in_w) &&
                    span_hit(rd_q.top, rd_q.height, in_y, in_h);
  assign stat.out_free = !out_v || out_ready;

  assign wr_e = cmd.wr_union ? uni_e : in_e;

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      in_x <= in_data.rect_x;
      in_y <= in_data.rect_y;
      in_w <= {1'b0, in_data.rect_w};
      in_h <= {1'b0, in_data.rect_h};
    end
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_e;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res.kind <= cmd.res_kind;
      res.last <= 1'b1;
      unique case (cmd.res_kind)
        KIND_MERGED: begin
          res.out_x <= uni_e.left;
          res.out_y <= uni_e.top;
          res.out_w <= uni_e.width;
          res.out_h <= uni_e.height;
        end
        KIND_INSERTED, KIND_DROPPED: begin
          res.out_x <= in_x;
          res.out_y <= in_y;
          res.out_w <= in_w;
          res.out_h <= in_h;
        end
        default: begin
          res.out_x <= '0;
          res.out_y <= '0;
          res.out_w <= '0;
          res.out_h <= '0;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (cmd.out_ld_res || cmd.out_ld_flush) begin
      out_v <= 1'b1;
    end else if (out_ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld_res) begin
      out_q <= res;
    end else if (cmd.out_ld_flush) begin
      out_q <= '{kind: KIND_FLUSHED, out_x: rd_q.left, out_y: rd_q.top,
                 out_w: rd_q.width, out_h: rd_q.height, last: cmd.flush_last};
    end
  end

  assign out_valid = out_v;
  assign out_data  = out_q;

  `DRM_ASSERT(a_load_free, clk, rst, !(cmd.out_ld_res || cmd.out_ld_flush) || stat.out_free, "output word overwritten before taken")

endmodule

// ===== sv/dirty_rect_merge_table.sv =====
// ---------------------------------------------------------------------------
// dirty_rect_merge_table
// table of dirty screen rectangles with overlap merge and flush
// ---------------------------------------------------------------------------
// An add word searches the stored rectangles newest to oldest, one entry per
// cycle through the single read port of the table memory; the first entry
// with a positive-area overlap is replaced by the bounding union and one
// merged word is returned. With no overlap the rectangle is appended (or
// reported as dropped when the table holds TABLE_DEPTH entries). An add that
// hits passes through idle, the scan steps up to the hit and emit; a miss
// scans every stored entry and adds an insert step before emit, and the emit
// step waits for the output register to be taken. A flush streams every
// entry newest first, one word per cycle while the result side keeps taking
// them, last set on the oldest one, then empties the table; a flush of an
// empty table gives one KIND_EMPTY word with zero rectangle fields and last set.
// The next word is taken as soon as the controller is back in idle, even
// while the previous result still waits in the output register.
// The table holds no reset value: only entries below the fill count are read.
// ---------------------------------------------------------------------------
module dirty_rect_merge_table import drm_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input logic          clk,
  input logic          rst,
  drm_stream_if.sink   item,
  drm_stream_if.source result
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // control and status between sequencer and datapath
  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  item_word_t    item_word;
  result_word_t  result_word;

  assign item_word   = item.data;
  assign result.data = result_word;

  // state machine: scan, insert, flush and emit sequencing
  drm_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_action (item_word.action),
    .item_ready  (item.ready),
    .stat        (stat),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr)
  );

  // table memory, overlap test, union and output register
  drm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (item_word),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .stat      (stat),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result_word)
  );

endmodule
